// ===== design/plc_pkg.sv =====
// Shared types, codes and field widths of the point leader clustering unit.
package plc_pkg;

  localparam int unsigned ThreshW  = 13;
  localparam int unsigned LimitW   = 5;
  localparam int unsigned OutcomeW = 2;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned TotalW   = 5;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(8);
  localparam logic [LimitW-1:0]  LimitReset  = LimitW'(16);

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LIMIT     = CfgIdxW'(1);

  typedef enum logic [OutcomeW-1:0] {
    OUTCOME_JOIN = 2'd0,
    OUTCOME_NEW  = 2'd1,
    OUTCOME_FAIL = 2'd2
  } outcome_e;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic hit;
    logic last_leader;
    logic out_free;
  } sts_t;

endpackage

// ===== design/plc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module plc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/plc_ctrl.sv =====
// Controller state machine: accepts a point, steps the leader scan, commits the result.
module plc_ctrl
  import plc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = sts_i.skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.last_leader) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result waits here until the output register can take it.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result committed while the output register is occupied");

  a_skip_goes_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture && sts_i.skip) |=> (state_q == ST_FINISH))
    else $error("scan started for a point that needs no comparison");

endmodule

// ===== design/plc_datapath.sv =====
// Datapath: configuration, point and leader storage, distance compare and result register.
module plc_datapath
  import plc_pkg::*;
#(
  parameter int unsigned MaxLeaders = 16,
  parameter int unsigned CoordBits  = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [CoordBits-1:0] point_x_i,
  input  logic [CoordBits-1:0] point_y_i,
  input  logic                 last_point_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [ThreshW-1:0]   cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutcomeW-1:0]  outcome_o,
  output logic [IndexW-1:0]    cluster_index_o,
  output logic [TotalW-1:0]    cluster_total_o,
  output logic                 set_end_o
);

  localparam int unsigned IdxW  = (MaxLeaders > 1) ? $clog2(MaxLeaders) : 1;
  localparam int unsigned CntW  = $clog2(MaxLeaders + 1);
  localparam int unsigned LimW  = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned DistW = CoordBits + 1;
  localparam int unsigned CmpW  = (DistW > ThreshW) ? DistW : ThreshW;
  localparam int unsigned EntW  = 2 * CoordBits;

  logic [ThreshW-1:0]   thresh_q;
  logic [LimitW-1:0]    limit_q;
  logic [CoordBits-1:0] px_q, py_q;
  logic                 last_q;
  logic [IdxW-1:0]      idx_q;
  logic                 found_q;
  logic [CntW-1:0]      count_q;
  logic                 failed_q;
  logic                 out_valid_q;
  outcome_e             outcome_q;
  logic [IndexW-1:0]    index_q;
  logic [TotalW-1:0]    total_q;
  logic                 set_end_q;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [EntW-1:0]      rd_data;
  logic                 wr_en;
  logic [CoordBits-1:0] lx, ly, dx, dy;
  logic [DistW-1:0]     manh_dist;
  logic                 hit;
  logic                 last_leader;
  logic                 full;
  logic                 out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      limit_q  <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thresh_q <= cfg_data_i;
        CFG_LIMIT:     limit_q  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Distance from the held point to the leader just read.
  assign lx        = rd_data[EntW-1:CoordBits];
  assign ly        = rd_data[CoordBits-1:0];
  assign dx        = (px_q >= lx) ? (px_q - lx) : (lx - px_q);
  assign dy        = (py_q >= ly) ? (py_q - ly) : (ly - py_q);
  assign manh_dist = {1'b0, dx} + {1'b0, dy};
  assign hit       = CmpW'(manh_dist) <= CmpW'(thresh_q);

  assign last_leader = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign full        = (LimW'(count_q) >= LimW'(limit_q)) ||
                       (count_q == CntW'(MaxLeaders));
  assign out_free    = !out_valid_q || out_ready_i;

  assign sts_o.skip        = failed_q || (count_q == '0);
  assign sts_o.hit         = hit;
  assign sts_o.last_leader = last_leader;
  assign sts_o.out_free    = out_free;

  assign rd_en   = cmd_i.capture || (cmd_i.scan_step && !hit && !last_leader);
  assign rd_addr = cmd_i.capture ? '0 : (idx_q + IdxW'(1));
  assign wr_en   = cmd_i.commit && !failed_q && !found_q && !full;

  plc_ram #(
    .Width (EntW),
    .Depth (MaxLeaders)
  ) u_leader_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({px_q, py_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Held point and scan position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (hit) begin
        found_q <= 1'b1;
      end else if (!last_leader) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      last_q <= last_point_i;
    end
  end

  // Set state: leader count and sticky failure.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      failed_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (last_q) begin
        count_q  <= '0;
        failed_q <= 1'b0;
      end else if (!failed_q && !found_q) begin
        if (full) begin
          failed_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      set_end_q <= last_q;
      if (failed_q) begin
        outcome_q <= OUTCOME_FAIL;
        index_q   <= '0;
        total_q   <= TotalW'(count_q);
      end else if (found_q) begin
        outcome_q <= OUTCOME_JOIN;
        index_q   <= IndexW'(idx_q);
        total_q   <= TotalW'(count_q);
      end else if (full) begin
        outcome_q <= OUTCOME_FAIL;
        index_q   <= '0;
        total_q   <= TotalW'(count_q);
      end else begin
        outcome_q <= OUTCOME_NEW;
        index_q   <= IndexW'(count_q);
        total_q   <= TotalW'(count_q + CntW'(1));
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = outcome_q;
  assign cluster_index_o = index_q;
  assign cluster_total_o = total_q;
  assign set_end_o       = set_end_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxLeaders))
    else $error("leader count beyond table capacity");

  a_set_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && last_q) |=> ((count_q == '0) && !failed_q))
    else $error("set state not cleared after the last point");

endmodule

// ===== design/point_leader_clustering_unit.sv =====
// Top level of the point leader clustering unit: controller, datapath and ports.
// A request is accepted in idle, then compares one leader per scan step and commits its result
// to the output register; no leader is compared for an empty table or a failed set.
// A new request is accepted only after the commit of the last one; a result still
// held in the output register stalls the commit. The scan stops at the first close leader.
// Reset clears the leader count, the failure flag and the output valid, and loads the
// threshold with 8 and the cluster limit with 16; leader RAM contents are not cleared.
module point_leader_clustering_unit
  import plc_pkg::*;
#(
  parameter int unsigned MAX_LEADERS = 16,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic                  last_point_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OutcomeW-1:0]   outcome_o,
  output logic [IndexW-1:0]     cluster_index_o,
  output logic [TotalW-1:0]     cluster_total_o,
  output logic                  set_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [ThreshW-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  plc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plc_datapath #(
    .MaxLeaders (MAX_LEADERS),
    .CoordBits  (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .last_point_i    (last_point_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .outcome_o       (outcome_o),
    .cluster_index_o (cluster_index_o),
    .cluster_total_o (cluster_total_o),
    .set_end_o       (set_end_o)
  );

endmodule
